[hdl/teb_pkg.sv]
// Shared types, constants and helpers for the tagged event ring buffer.
package teb_pkg;

    localparam int DEF_RING_DEPTH    = 64;
    localparam int DEF_PAYLOAD_BYTES = 8;
    localparam int DEF_ID_BITS       = 16;

    localparam int ID_PORT_W   = 16;
    localparam int SIZE_W      = 4;
    localparam int DATA_PORT_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_SCAN,
        ST_POP_WR,
        ST_SKIP_START,
        ST_SKIP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_write;
        logic skip_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic oversize;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } status_t;

    // Keep the low n bytes of a word, zero the rest.
    function automatic logic [DATA_PORT_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_PORT_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_PORT_W / 8; i++)
        begin
            if (SIZE_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

[hdl/teb_ctrl.sv]
// Sequencer for the tagged event ring buffer: steps publish, pop and skip phases.
module teb_ctrl
    import teb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_pop)
                begin
                    state_next = ST_POP_SCAN;
                end
                else if (status.oversize)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SKIP_START;
                end
            end
            ST_POP_SCAN:
            begin
                if (status.scan_hit)
                begin
                    state_next = ST_POP_WR;
                end
                else if (status.scan_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_POP_WR:     state_next = ST_SKIP_START;
            ST_SKIP_START: state_next = ST_SKIP;
            ST_SKIP:
            begin
                if (status.scan_hit || status.scan_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_EXEC:       cmd.exec       = 1'b1;
            ST_POP_WR:     cmd.pop_write  = 1'b1;
            ST_SKIP_START: cmd.skip_start = 1'b1;
            ST_RESULT:     cmd.load_out   = status.out_free;
            default:       cmd            = '0;
        endcase
    end

endmodule

[hdl/teb_datapath.sv]
// Entry memory, ring pointers, scan pipeline and result register of the ring buffer.
module teb_datapath
    import teb_pkg::*;
#(
    parameter int RING_DEPTH    = DEF_RING_DEPTH,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int ID_BITS       = DEF_ID_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   action,
    input  logic [ID_PORT_W-1:0]   source_id,
    input  logic [SIZE_W-1:0]      byte_count,
    input  logic [DATA_PORT_W-1:0] payload,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [SIZE_W-1:0]      bytes_returned,
    output logic [DATA_PORT_W-1:0] data_out
);

    localparam int PtrW   = $clog2(RING_DEPTH);
    localparam int IdW    = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
    localparam int DataW  = 8 * PAYLOAD_BYTES;
    localparam int WordW  = 1 + SIZE_W + IdW + DataW;
    localparam int IdLo   = DataW;
    localparam int SizeLo = DataW + IdW;
    localparam int PopBit = WordW - 1;

    function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
        return (p == PtrW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry word: popped mark, size, id, data.
    logic [WordW-1:0] entry_mem [RING_DEPTH];

    logic [PtrW-1:0]  head_reg, head_next;
    logic [PtrW-1:0]  oldest_reg, oldest_next;
    logic             scan_act_reg, scan_act_next;
    logic             scan_pop_reg, scan_pop_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             out_valid_reg, out_valid_next;

    logic             act_reg;
    logic [IdW-1:0]   id_reg;
    logic [SIZE_W-1:0] cnt_reg;
    logic [DataW-1:0] pay_reg;
    logic [PtrW-1:0]  scan_ptr_reg;
    logic [PtrW-1:0]  chk_ptr_reg;
    logic [WordW-1:0] rd_word_reg;
    logic             res_ok_reg;
    logic [SIZE_W-1:0] res_n_reg;
    logic [DataW-1:0] res_data_reg;
    logic             out_ok_reg;
    logic [SIZE_W-1:0] out_n_reg;
    logic [DataW-1:0] out_data_reg;

    logic             rd_popped;
    logic [SIZE_W-1:0] rd_size;
    logic [IdW-1:0]   rd_id;
    logic [DataW-1:0] rd_data;
    logic             match;
    logic             scan_hit;
    logic             scan_end;
    logic             issue;
    logic             oversize;
    logic             pub_ok;
    logic             scan_start;
    logic [SIZE_W-1:0] pop_n;
    logic [DATA_PORT_W-1:0] pop_mask;
    logic [DATA_PORT_W-1:0] pub_mask;
    logic             mem_we;
    logic [PtrW-1:0]  mem_waddr;
    logic [WordW-1:0] mem_wdata;
    logic [PtrW-1:0]  head_plus;

    always_comb
    begin
        rd_popped  = rd_word_reg[PopBit];
        rd_size    = rd_word_reg[SizeLo +: SIZE_W];
        rd_id      = rd_word_reg[IdLo +: IdW];
        rd_data    = rd_word_reg[DataW-1:0];
        // A pop seeks an un-popped entry with its id; a skip any un-popped entry.
        match      = !rd_popped && (!scan_pop_reg || (rd_id == id_reg));
        scan_hit   = scan_act_reg && chk_vld_reg && match;
        scan_end   = scan_act_reg && !chk_vld_reg && (scan_ptr_reg == head_reg);
        issue      = scan_act_reg && !scan_hit && (scan_ptr_reg != head_reg);
        oversize   = cnt_reg > SIZE_W'(PAYLOAD_BYTES);
        pub_ok     = cmd.exec && !act_reg && !oversize;
        scan_start = (cmd.exec && act_reg) || cmd.skip_start;
        pop_n      = (cnt_reg < rd_size) ? cnt_reg : rd_size;
        pop_mask   = byte_mask(pop_n);
        pub_mask   = byte_mask(cnt_reg);
        head_plus  = next_ptr(head_reg);
        mem_we     = pub_ok || cmd.pop_write;
        mem_waddr  = cmd.pop_write ? chk_ptr_reg : head_reg;
        mem_wdata  = cmd.pop_write ? {1'b1, rd_word_reg[WordW-2:0]}
                                   : {1'b0, cnt_reg, id_reg, pay_reg & pub_mask[DataW-1:0]};
    end

    always_comb
    begin
        head_next   = head_reg;
        oldest_next = oldest_reg;
        if (pub_ok)
        begin
            head_next = head_plus;
            // Full ring: drop the oldest entry.
            if (head_plus == oldest_reg)
            begin
                oldest_next = next_ptr(oldest_reg);
            end
        end
        if (!scan_pop_reg && scan_hit)
        begin
            oldest_next = chk_ptr_reg;
        end
        else if (!scan_pop_reg && scan_end)
        begin
            oldest_next = head_reg;
        end

        scan_act_next = scan_act_reg;
        if (scan_start)
        begin
            scan_act_next = 1'b1;
        end
        else if (scan_hit || scan_end)
        begin
            scan_act_next = 1'b0;
        end

        scan_pop_next = scan_pop_reg;
        if (cmd.exec)
        begin
            scan_pop_next = act_reg;
        end
        else if (cmd.skip_start)
        begin
            scan_pop_next = 1'b0;
        end

        chk_vld_next = issue;

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            oldest_reg    <= '0;
            scan_act_reg  <= 1'b0;
            scan_pop_reg  <= 1'b0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            oldest_reg    <= oldest_next;
            scan_act_reg  <= scan_act_next;
            scan_pop_reg  <= scan_pop_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            id_reg  <= source_id[IdW-1:0];
            cnt_reg <= byte_count;
            pay_reg <= payload[DataW-1:0];
        end
        if (scan_start)
        begin
            scan_ptr_reg <= oldest_reg;
        end
        else if (issue)
        begin
            scan_ptr_reg <= next_ptr(scan_ptr_reg);
        end
        if (issue)
        begin
            chk_ptr_reg <= scan_ptr_reg;
        end
        if (cmd.exec)
        begin
            res_ok_reg   <= !act_reg && !oversize;
            res_n_reg    <= '0;
            res_data_reg <= '0;
        end
        else if (scan_hit && scan_pop_reg)
        begin
            res_ok_reg   <= 1'b1;
            res_n_reg    <= pop_n;
            res_data_reg <= rd_data & pop_mask[DataW-1:0];
        end
        if (cmd.load_out)
        begin
            out_ok_reg   <= res_ok_reg;
            out_n_reg    <= res_n_reg;
            out_data_reg <= res_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_word_reg <= entry_mem[scan_ptr_reg];
        end
    end

    assign status.is_pop   = act_reg;
    assign status.oversize = oversize;
    assign status.scan_hit = scan_hit;
    assign status.scan_end = scan_end;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign ok             = out_ok_reg;
    assign bytes_returned = out_n_reg;
    assign data_out       = DATA_PORT_W'(out_data_reg);

endmodule

[hdl/tagged_event_ring_buffer.sv]
// Top level of the tagged event ring buffer: sequencer plus datapath.
//
// One ring of tagged events; use one instance per direction.
// Input channel (in_valid / in_stall) carries action, source_id, byte_count
// and payload. action 0 publishes: the entry is written at the head, the
// oldest entry is dropped when the ring is full. action 1 pops: the live
// entries are scanned from the oldest toward the head for the first
// un-popped entry with a matching id, which is marked popped and returned.
// Output channel (out_valid / out_stall) gives one result transfer per item:
// ok, bytes_returned and data_out (bytes past bytes_returned read zero).
// One item is handled at a time. A publish that is not oversize and a pop that
// finds its entry end with a skip scan that moves the oldest pointer past
// popped entries; a pop first scans the live entries for its match. Both scans
// are paced by the single read port of the entry memory, which the scan walks
// one slot per cycle.
// The finished result sits in an output register; if the receiver stalls,
// hold it there. in_stall drops as soon as the result is loaded, so the next
// item is taken and worked meanwhile; it then waits in its result phase,
// with in_stall high, until the output register is free.
// Reset clears the head and oldest pointers (empty ring) and the control
// state; the entry memory needs no clearing pass.
module tagged_event_ring_buffer
    import teb_pkg::*;
#(
    parameter int RING_DEPTH    = DEF_RING_DEPTH,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int ID_BITS       = DEF_ID_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [ID_PORT_W-1:0]   source_id,
    input  logic [SIZE_W-1:0]      byte_count,
    input  logic [DATA_PORT_W-1:0] payload,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [SIZE_W-1:0]      bytes_returned,
    output logic [DATA_PORT_W-1:0] data_out
);

    cmd_t    cmd;
    status_t status;

    // Sequence the phases of each item.
    teb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the ring, walk it, and register the result transfer.
    teb_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .ID_BITS       (ID_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .source_id      (source_id),
        .byte_count     (byte_count),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .bytes_returned (bytes_returned),
        .data_out       (data_out)
    );

endmodule

[hdl/teb_checker.sv]
// Port-level checks for the tagged event ring buffer, bound to the top level.
module teb_checker
    import teb_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   ok,
    input logic [SIZE_W-1:0]      bytes_returned,
    input logic [DATA_PORT_W-1:0] data_out
);

    // One item at a time: busy right after a transfer in.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous item in flight");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (bytes_returned == '0) && (data_out == '0))
        else $error("failed item returned data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bytes_returned <= SIZE_W'(PAYLOAD_BYTES))
        else $error("bytes_returned above payload size");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (data_out & ~byte_mask(bytes_returned)) == '0)
        else $error("data_out bytes past bytes_returned not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(ok))
        else $error("stalled result changed");

endmodule

bind tagged_event_ring_buffer teb_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_teb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .bytes_returned (bytes_returned),
    .data_out       (data_out)
);

[sim/tagged_event_ring_buffer_tb.sv]
// Self-checking testbench for the tagged event ring buffer: random traffic with a ring predictor.
module tagged_event_ring_buffer_tb;
    import teb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = DEF_RING_DEPTH;
    localparam int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES;
    localparam int ID_BITS       = DEF_ID_BITS;

    // Action codes carried on the action port.
    localparam logic ACT_PUBLISH = 1'b0;
    localparam logic ACT_POP     = 1'b1;

    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * RING_DEPTH + 20;

    typedef struct packed {
        logic                   act;
        logic [ID_PORT_W-1:0]   id;
        logic [SIZE_W-1:0]      cnt;
        logic [DATA_PORT_W-1:0] data;
    } ring_item_t;

    typedef struct packed {
        logic                   ok;
        logic [SIZE_W-1:0]      nbytes;
        logic [DATA_PORT_W-1:0] data;
    } pop_result_t;

    // Clock, reset and block ports. Drive every input to a known value from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   action = ACT_PUBLISH;
    logic [ID_PORT_W-1:0]   source_id = '0;
    logic [SIZE_W-1:0]      byte_count = '0;
    logic [DATA_PORT_W-1:0] payload = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   ok;
    logic [SIZE_W-1:0]      bytes_returned;
    logic [DATA_PORT_W-1:0] data_out;

    // Stimulus waiting for the driver, and results waiting for the output side.
    ring_item_t  pending_items[$];
    pop_result_t awaited_results[$];

    int total_items = 0;
    int accepted_count = 0;
    int idle_phase;
    int cycle_count = 0;
    bit mismatch_seen = 1'b0;

    // Predictor copy of the ring: entry store plus head and oldest pointers.
    logic [DATA_PORT_W-1:0] ring_data   [RING_DEPTH];
    logic [SIZE_W-1:0]      ring_size   [RING_DEPTH];
    logic [ID_BITS-1:0]     ring_id     [RING_DEPTH];
    logic                   ring_popped [RING_DEPTH];
    int head_ptr = 0;
    int oldest_ptr = 0;

    tagged_event_ring_buffer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .source_id      (source_id),
        .byte_count     (byte_count),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .bytes_returned (bytes_returned),
        .data_out       (data_out)
    );

    // 10 ns clock: 5 ns low, 5 ns high.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Split the run in thirds by accepted transfers: sender idles 25 / receiver 75,
    // then swap, then run both sides flat out.
    assign idle_phase = (total_items == 0) ? 0 : (accepted_count * 3) / total_items;

    // Mask that keeps the low n bytes of a word.
    function automatic logic [DATA_PORT_W-1:0] keep_low_bytes(input logic [SIZE_W-1:0] n);
        if (n >= 8)
        begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Apply one accepted item to the predictor ring and return the result it must produce.
    function automatic pop_result_t apply_to_ring(input ring_item_t it);
        pop_result_t        res;
        int                 p;
        bit                 hit;
        logic [SIZE_W-1:0]  n;
        logic [ID_BITS-1:0] key;
        res = '0;
        hit = 1'b0;
        key = it.id[ID_BITS-1:0];
        if (it.act == ACT_PUBLISH)
        begin
            // Reject an oversize publish, leave the ring untouched.
            if (it.cnt <= PAYLOAD_BYTES)
            begin
                ring_data[head_ptr]   = it.data & keep_low_bytes(it.cnt);
                ring_size[head_ptr]   = it.cnt;
                ring_id[head_ptr]     = key;
                ring_popped[head_ptr] = 1'b0;
                head_ptr = (head_ptr + 1) % RING_DEPTH;
                // Drop the oldest entry when the head catches up with it.
                if (head_ptr == oldest_ptr)
                begin
                    oldest_ptr = (oldest_ptr + 1) % RING_DEPTH;
                end
                res.ok = 1'b1;
            end
        end
        else
        begin
            // Scan oldest toward head for the first live, un-popped entry with this id.
            p = oldest_ptr;
            while (p != head_ptr && !hit)
            begin
                if (!ring_popped[p] && ring_id[p] == key)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    p = (p + 1) % RING_DEPTH;
                end
            end
            if (hit)
            begin
                n = (it.cnt < ring_size[p]) ? it.cnt : ring_size[p];
                res.ok     = 1'b1;
                res.nbytes = n;
                res.data   = ring_data[p] & keep_low_bytes(n);
                ring_popped[p] = 1'b1;
            end
        end
        // Advance the oldest pointer past popped entries, stopping at the head.
        while (oldest_ptr != head_ptr && ring_popped[oldest_ptr])
        begin
            oldest_ptr = (oldest_ptr + 1) % RING_DEPTH;
        end
        return res;
    endfunction

    task automatic queue_item(input logic act, input logic [ID_PORT_W-1:0] id,
                              input logic [SIZE_W-1:0] cnt, input logic [DATA_PORT_W-1:0] data);
        ring_item_t it;
        it.act  = act;
        it.id   = id;
        it.cnt  = cnt;
        it.data = data;
        pending_items.push_back(it);
    endtask

    // Input driver: present the next queued item once the slot is free, idling at
    // random. Hold the payload while stalled; each signal gets one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        ring_item_t nxt;
        int         idle_pct;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            idle_pct = (idle_phase == 0) ? 25 : (idle_phase == 1) ? 75 : 0;
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_items.pop_front();
                in_valid   <= 1'b1;
                action     <= nxt.act;
                source_id  <= nxt.id;
                byte_count <= nxt.cnt;
                payload    <= nxt.data;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random by phase. Stall may depend on anything.
    always @(posedge clk or negedge rst_n)
    begin : drive_stall
        int stall_pct;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_pct = (idle_phase == 0) ? 75 : (idle_phase == 1) ? 25 : 0;
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: on each input transfer predict the result; on each output transfer
    // compare it field by field with the oldest prediction.
    always @(posedge clk)
    begin : watch_transfers
        ring_item_t  seen;
        pop_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen.act  = action;
                seen.id   = source_id;
                seen.cnt  = byte_count;
                seen.data = payload;
                awaited_results.push_back(apply_to_ring(seen));
                accepted_count <= accepted_count + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with nothing awaited: ok %0d bytes %0d data %h",
                           ok, bytes_returned, data_out);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, ok);
                        mismatch_seen = 1'b1;
                    end
                    if (bytes_returned !== want.nbytes)
                    begin
                        $error("bytes_returned: expected %0d, got %0d",
                               want.nbytes, bytes_returned);
                        mismatch_seen = 1'b1;
                    end
                    if (data_out !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, data_out);
                        mismatch_seen = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : run_test
        logic [ID_PORT_W-1:0] id_pool [8];
        int                   kind;
        int                   burst;
        logic [ID_PORT_W-1:0] pick;
        logic [SIZE_W-1:0]    cnt;

        // Directed part: empty-ring pop, extreme ids and payloads, zero-size entry,
        // short payload, oversize publishes, zero-byte pop, partial pop, no match.
        queue_item(ACT_POP,     16'h0000, 4'd8,  '0);
        queue_item(ACT_PUBLISH, 16'h0000, 4'd8,  '1);
        queue_item(ACT_PUBLISH, 16'hFFFF, 4'd0,  '1);
        queue_item(ACT_PUBLISH, 16'h1234, 4'd3,  64'hFEDC_BA98_7654_3210);
        queue_item(ACT_PUBLISH, 16'h1234, 4'd9,  64'h0123_4567_89AB_CDEF);
        queue_item(ACT_PUBLISH, 16'h1234, 4'd15, '1);
        queue_item(ACT_PUBLISH, 16'hA5A5, 4'd5,  64'h8877_6655_4433_2211);
        queue_item(ACT_POP,     16'hFFFF, 4'd15, '0);
        queue_item(ACT_POP,     16'h1234, 4'd15, '1);
        queue_item(ACT_POP,     16'h1234, 4'd4,  '0);
        queue_item(ACT_POP,     16'h0000, 4'd0,  '0);
        queue_item(ACT_POP,     16'hA5A5, 4'd2,  '0);
        queue_item(ACT_PUBLISH, 16'h5A5A, 4'd1,  '0);
        queue_item(ACT_PUBLISH, 16'h5A5A, 4'd8,  {$urandom, $urandom});
        queue_item(ACT_POP,     16'h5A5A, 4'd8,  '0);
        queue_item(ACT_POP,     16'h5A5A, 4'd8,  '0);
        queue_item(ACT_POP,     16'h5A5A, 4'd8,  '0);

        // Random part: a small id pool so pops find matches; long publish bursts
        // to fill and overflow the ring, pop bursts to drain it, and some noise.
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
        begin
            id_pool[i] = 16'($urandom);
        end
        while (pending_items.size() < RANDOM_ITEMS)
        begin
            kind = $urandom_range(9);
            burst = (kind == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
            for (int i = 0; i < burst; i++)
            begin
                pick = id_pool[$urandom_range(7)];
                if (kind == 9)
                begin
                    queue_item(1'($urandom), 16'($urandom), 4'($urandom), {$urandom, $urandom});
                end
                else if (kind <= 4)
                begin
                    cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                   : 4'($urandom_range(8));
                    queue_item(ACT_PUBLISH, pick, cnt, {$urandom, $urandom});
                end
                else
                begin
                    queue_item(ACT_POP, pick, 4'($urandom_range(15)), {$urandom, $urandom});
                end
            end
        end
        total_items = pending_items.size();

        // Hold reset from time zero, then release it for good.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to transfer, every result to arrive, then let the
        // block settle before judging.
        while (accepted_count != total_items)
        begin
            @(posedge clk);
        end
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!mismatch_seen)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
hdl/teb_pkg.sv
hdl/teb_ctrl.sv
hdl/teb_datapath.sv
hdl/tagged_event_ring_buffer.sv
hdl/teb_checker.sv
sim/tagged_event_ring_buffer_tb.sv
